// ===== rtl/pspm_pkg.sv =====
package pspm_pkg;

  localparam int STATIONS    = 4;
  localparam int CHANS       = 2 * STATIONS;
  localparam int STORE_DEPTH = 18;
  localparam int DESC_BYTES  = 12;

  localparam logic [1:0] OP_POLL = 2'd0;
  localparam logic [1:0] OP_RX   = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;

  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [7:0] HDR_BYTE    = 8'hA5;
  localparam logic [7:0] ADDR_BASE   = 8'h61;
  localparam logic [7:0] CODE_READ   = 8'h81;
  localparam logic [7:0] CODE_SWITCH = 8'h82;
  localparam logic [7:0] END_BYTE    = 8'h26;
  localparam logic [7:0] CH1_BIT     = 8'h10;
  localparam logic [7:0] CH0_BIT     = 8'h01;
  localparam logic [7:0] CMD_SWITCH  = 8'h02;
  localparam logic [7:0] LEN_SWITCH  = 8'h06;
  localparam logic [7:0] CMD_QUERY   = 8'h01;
  localparam logic [7:0] LEN_QUERY   = 8'h05;

  localparam logic [4:0] EXP_SWITCH = 5'd9;
  localparam logic [4:0] EXP_QUERY  = 5'd29;
  localparam logic [4:0] EXP_RESET  = 5'd31;

  localparam logic [3:0] N_SWITCH = 4'd9;
  localparam logic [3:0] N_QUERY  = 4'd8;
  localparam logic [3:0] N_READ   = 4'd6;

  typedef struct packed {
    logic                        kind;
    logic [1:0]                  station;
    logic [3:0]                  count;
    logic [DESC_BYTES-1:0][7:0]  data;
    logic [15:0]                 success;
    logic [15:0]                 fail;
    logic [15:0]                 interval;
  } pspm_desc_t;

endpackage

// ===== rtl/power_station_poll_master.sv =====
// Results: the first result of an item appears the cycle after the item is accepted
// when no earlier results are queued; results then leave one per cycle while out_stall
// is low (8 or 9 per poll, 6 per good reading reply). Throughput: one item per cycle;
// input stalls only while a second result burst waits behind the one being sent.
// Reset (synchronous, active low): clears switch tables, counters, ticks and poll state;
// the receive byte store is not cleared.
module power_station_poll_master (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_rx_byte,
  input  logic [1:0]  in_target_station,
  input  logic        in_target_channel,
  input  logic        in_switch_on,
  input  logic [31:0] in_now_tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_tx_byte,
  output logic [1:0]  out_station,
  output logic [2:0]  out_reading_index,
  output logic [15:0] out_reading,
  output logic [15:0] out_success_count,
  output logic [15:0] out_fail_count,
  output logic [15:0] out_interval_ticks,
  output logic        out_last
);
  import pspm_pkg::*;

  logic [CHANS-1:0] desired_r, desired_nxt;
  logic [CHANS-1:0] confirmed_r, confirmed_nxt;
  logic [1:0]       poll_r, poll_nxt;
  logic             await_r, await_nxt;
  logic [7:0]       rx_count_r, rx_count_nxt;
  logic [4:0]       exp_len_r, exp_len_nxt;
  logic [15:0]      fail_r [STATIONS];
  logic [15:0]      fail_nxt [STATIONS];
  logic [15:0]      succ_r [STATIONS];
  logic [15:0]      succ_nxt [STATIONS];
  logic [31:0]      tick_r [STATIONS];
  logic [31:0]      tick_nxt [STATIONS];
  logic [7:0]       store_r [STORE_DEPTH];
  logic [7:0]       store_v [STORE_DEPTH];

  logic       accept;
  logic       push;
  pspm_desc_t desc;

  logic [7:0] cnt_inc;
  logic       parse;
  logic [7:0] rst8;
  logic [1:0] rst_st;
  logic       hdr_ok;
  logic [7:0] addr;
  logic       sw_diff;
  logic [7:0] chans;
  logic [15:0] fail_upd;

  assign accept  = in_valid && !in_stall;
  assign cnt_inc = (rx_count_r == 8'd255) ? 8'd255 : rx_count_r + 8'd1;
  assign parse   = await_r && (cnt_inc == {3'd0, exp_len_r});
  assign rst8    = store_v[3] - ADDR_BASE;
  assign rst_st  = rst8[1:0];
  assign hdr_ok  = (store_v[0] == SYNC_BYTE) && (store_v[1] == SYNC_BYTE)
                   && (store_v[2] == HDR_BYTE) && (rst8 < 8'(STATIONS));
  assign addr    = ADDR_BASE + {6'd0, poll_r};
  assign sw_diff = (desired_r[{poll_r, 1'b0}] != confirmed_r[{poll_r, 1'b0}])
                   || (desired_r[{poll_r, 1'b1}] != confirmed_r[{poll_r, 1'b1}]);
  assign chans   = (desired_r[{poll_r, 1'b0}] ? CH0_BIT : 8'd0)
                   | (desired_r[{poll_r, 1'b1}] ? CH1_BIT : 8'd0);
  assign fail_upd = await_r ? fail_r[poll_r] + 16'd1 : fail_r[poll_r];

  always_comb begin
    for (int k = 0; k < STORE_DEPTH; k++) begin
      store_v[k] = (rx_count_r == 8'(k)) ? in_rx_byte : store_r[k];
    end
  end

  always_comb begin
    desired_nxt   = desired_r;
    confirmed_nxt = confirmed_r;
    poll_nxt      = poll_r;
    await_nxt     = await_r;
    rx_count_nxt  = rx_count_r;
    exp_len_nxt   = exp_len_r;
    fail_nxt      = fail_r;
    succ_nxt      = succ_r;
    tick_nxt      = tick_r;
    push          = 1'b0;
    desc          = '0;
    if (accept) begin
      case (in_op)
        OP_POLL: begin
          push                 = 1'b1;
          fail_nxt[poll_r]     = fail_upd;
          rx_count_nxt         = 8'd0;
          await_nxt            = 1'b1;
          poll_nxt             = (poll_r == 2'(STATIONS - 1)) ? 2'd0 : poll_r + 2'd1;
          desc.kind            = KIND_TX;
          desc.station         = poll_r;
          desc.success         = succ_r[poll_r];
          desc.fail            = fail_upd;
          desc.data[0]         = SYNC_BYTE;
          desc.data[1]         = SYNC_BYTE;
          desc.data[2]         = HDR_BYTE;
          desc.data[3]         = addr;
          if (sw_diff) begin
            desc.count   = N_SWITCH;
            exp_len_nxt  = EXP_SWITCH;
            desc.data[4] = CMD_SWITCH;
            desc.data[5] = LEN_SWITCH;
            desc.data[6] = chans;
            desc.data[7] = addr + CMD_SWITCH + LEN_SWITCH + chans;
            desc.data[8] = END_BYTE;
          end else begin
            desc.count   = N_QUERY;
            exp_len_nxt  = EXP_QUERY;
            desc.data[4] = CMD_QUERY;
            desc.data[5] = LEN_QUERY;
            desc.data[6] = addr + CMD_QUERY + LEN_QUERY;
            desc.data[7] = END_BYTE;
          end
        end
        OP_RX: begin
          rx_count_nxt = cnt_inc;
          if (parse && hdr_ok) begin
            await_nxt = 1'b0;
            if (store_v[4] == CODE_READ) begin
              push             = 1'b1;
              succ_nxt[rst_st] = succ_r[rst_st] + 16'd1;
              tick_nxt[rst_st] = in_now_tick;
              desc.kind        = KIND_READ;
              desc.station     = rst_st;
              desc.count       = N_READ;
              desc.success     = succ_r[rst_st] + 16'd1;
              desc.fail        = fail_r[rst_st];
              desc.interval    = 16'(in_now_tick - tick_r[rst_st]);
              for (int k = 0; k < DESC_BYTES; k++) begin
                desc.data[k] = store_v[6 + k];
              end
            end else if (store_v[4] == CODE_SWITCH) begin
              confirmed_nxt[{rst_st, 1'b0}] = desired_r[{rst_st, 1'b0}];
              confirmed_nxt[{rst_st, 1'b1}] = desired_r[{rst_st, 1'b1}];
            end
          end
        end
        OP_SET: begin
          if ({1'b0, in_target_station} < 3'(STATIONS)) begin
            desired_nxt[{in_target_station, in_target_channel}] = in_switch_on;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desired_r   <= '0;
      confirmed_r <= '0;
      poll_r      <= 2'd0;
      await_r     <= 1'b0;
      rx_count_r  <= 8'd0;
      exp_len_r   <= EXP_RESET;
      for (int s = 0; s < STATIONS; s++) begin
        fail_r[s] <= 16'd0;
        succ_r[s] <= 16'd0;
        tick_r[s] <= 32'd0;
      end
    end else begin
      desired_r   <= desired_nxt;
      confirmed_r <= confirmed_nxt;
      poll_r      <= poll_nxt;
      await_r     <= await_nxt;
      rx_count_r  <= rx_count_nxt;
      exp_len_r   <= exp_len_nxt;
      fail_r      <= fail_nxt;
      succ_r      <= succ_nxt;
      tick_r      <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_RX) && (rx_count_r < 8'(STORE_DEPTH))) begin
      store_r[rx_count_r[4:0]] <= in_rx_byte;
    end
  end

  pspm_burst u_burst (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .desc               (desc),
    .full               (in_stall),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_tx_byte        (out_tx_byte),
    .out_station        (out_station),
    .out_reading_index  (out_reading_index),
    .out_reading        (out_reading),
    .out_success_count  (out_success_count),
    .out_fail_count     (out_fail_count),
    .out_interval_ticks (out_interval_ticks),
    .out_last           (out_last)
  );

`ifndef ASSERT_OFF
  a_poll_arms: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_op == OP_POLL) |=> await_r && (rx_count_r == 8'd0))
    else $error("poll did not arm reply wait");

  a_poll_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_op == OP_POLL) |=> out_valid)
    else $error("poll beat produced no result");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_exp_len: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_len_r == EXP_SWITCH) || (exp_len_r == EXP_QUERY) || (exp_len_r == EXP_RESET))
    else $error("expected reply length corrupt");
`endif

endmodule

// ===== rtl/pspm_burst.sv =====
module pspm_burst (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pspm_pkg::pspm_desc_t desc,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [7:0]           out_tx_byte,
  output logic [1:0]           out_station,
  output logic [2:0]           out_reading_index,
  output logic [15:0]          out_reading,
  output logic [15:0]          out_success_count,
  output logic [15:0]          out_fail_count,
  output logic [15:0]          out_interval_ticks,
  output logic                 out_last
);
  import pspm_pkg::*;

  logic       act_v_r, act_v_nxt;
  pspm_desc_t act_r, act_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       pend_v_r, pend_v_nxt;
  pspm_desc_t pend_r, pend_nxt;

  logic fire, at_end, done, free;

  assign fire   = act_v_r && !out_stall;
  assign at_end = (idx_r == act_r.count - 4'd1);
  assign done   = fire && at_end;
  assign free   = !act_v_r || done;
  assign full   = pend_v_r;

  always_comb begin
    act_v_nxt  = act_v_r;
    act_nxt    = act_r;
    idx_nxt    = idx_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    if (free) begin
      idx_nxt = 4'd0;
      if (pend_v_r) begin
        act_v_nxt  = 1'b1;
        act_nxt    = pend_r;
        pend_v_nxt = 1'b0;
      end else begin
        act_v_nxt = push;
        act_nxt   = desc;
      end
    end else begin
      if (fire) begin
        idx_nxt = idx_r + 4'd1;
      end
      if (push) begin
        pend_v_nxt = 1'b1;
        pend_nxt   = desc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      idx_r    <= 4'd0;
    end else begin
      act_v_r  <= act_v_nxt;
      pend_v_r <= pend_v_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid          = act_v_r;
  assign out_kind           = act_r.kind;
  assign out_station        = act_r.station;
  assign out_success_count  = act_r.success;
  assign out_fail_count     = act_r.fail;
  assign out_interval_ticks = (act_r.kind == KIND_READ) ? act_r.interval : 16'd0;
  assign out_last           = at_end;
  assign out_tx_byte        = (act_r.kind == KIND_TX) ? act_r.data[idx_r] : 8'd0;
  assign out_reading_index  = (act_r.kind == KIND_READ) ? idx_r[2:0] : 3'd0;
  assign out_reading        = (act_r.kind == KIND_READ)
                              ? {act_r.data[{idx_r[2:0], 1'b0}], act_r.data[{idx_r[2:0], 1'b1}]}
                              : 16'd0;

endmodule
